[design/cbls_pkg.sv]
// Package for the chunked body line splitter.
// Holds the result record, character codes and hex/whitespace helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cbls_pkg;

	localparam int SIZE_BITS_DEF = 32;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;
	localparam logic [7:0] HEX_TEN  = 8'h0A;

	typedef struct packed {
		logic       lead_cr;
		logic       has_byte;
		logic [7:0] out_byte;
		logic       line_end;
	} result_t;

	// Returns {is_hex, digit value}.
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [7:0] t;
		t = 8'h00;
		if (b >= CH_0 && b <= CH_9) begin
			t = b - CH_0;
			return {1'b1, t[3:0]};
		end else if (b >= CH_LA && b <= CH_LF_HEX) begin
			t = b - CH_LA + HEX_TEN;
			return {1'b1, t[3:0]};
		end else if (b >= CH_UA && b <= CH_UF) begin
			t = b - CH_UA + HEX_TEN;
			return {1'b1, t[3:0]};
		end
		return 5'b0_0000;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF;
	endfunction

endpackage

`default_nettype wire

[design/cbls_in_stage.sv]
// Input register stage of the chunked body line splitter.
// Holds one accepted byte until the decoder consumes it. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module cbls_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       take,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	// The slot refills in the same cycle that it is drained.
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

`default_nettype wire

[design/cbls_decoder.sv]
// Chunk decoder: size line parser, data countdown, trailer swallow and CR hold.
// Depends on cbls_pkg for the result record and character helpers.
`timescale 1ns / 1ps
`default_nettype none

module cbls_decoder
	import cbls_pkg::*;
#(
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] byte_in,
	output logic            res_valid,
	output result_t         res
);

	typedef enum logic [1:0] {PH_SIZE, PH_DATA, PH_TRAIL, PH_DONE} phase_t;

	phase_t                 phase_q, phase_d;
	logic [SIZE_BITS-1:0]   accum_q, accum_d;
	logic                   digit_seen_q, digit_seen_d;
	logic                   stopped_q, stopped_d;
	logic [SIZE_BITS-1:0]   left_q, left_d;
	logic                   trail_q, trail_d;
	logic                   cr_q, cr_d;
	logic [4:0]             hex;

	assign hex = hex_value(byte_in);

	always_comb begin
		phase_d      = phase_q;
		accum_d      = accum_q;
		digit_seen_d = digit_seen_q;
		stopped_d    = stopped_q;
		left_d       = left_q;
		trail_d      = trail_q;
		cr_d         = cr_q;
		res_valid    = 1'b0;
		res          = '0;
		unique case (phase_q)
			PH_SIZE: begin
				if (byte_in == CH_LF) begin
					if (digit_seen_q && accum_q != '0) begin
						left_d  = accum_q;
						phase_d = PH_DATA;
					end else begin
						phase_d = PH_DONE;
					end
					accum_d      = '0;
					digit_seen_d = 1'b0;
					stopped_d    = 1'b0;
				end else if (byte_in != CH_CR && !stopped_q) begin
					if (hex[4]) begin
						// Any bit in the top nibble means the shift would overflow.
						if (accum_q[SIZE_BITS-1 -: 4] != 4'h0) begin
							accum_d = '1;
						end else begin
							accum_d = {accum_q[SIZE_BITS-5:0], hex[3:0]};
						end
						digit_seen_d = 1'b1;
					end else if (!(is_space(byte_in) && !digit_seen_q)) begin
						stopped_d = 1'b1;
					end
				end
			end
			PH_DATA: begin
				if (byte_in == CH_LF) begin
					cr_d          = 1'b0;
					res_valid     = 1'b1;
					res.line_end  = 1'b1;
				end else if (byte_in == CH_CR) begin
					if (cr_q) begin
						res_valid   = 1'b1;
						res.lead_cr = 1'b1;
					end
					cr_d = 1'b1;
				end else begin
					res_valid    = 1'b1;
					res.lead_cr  = cr_q;
					res.has_byte = 1'b1;
					res.out_byte = byte_in;
					cr_d         = 1'b0;
				end
				left_d = left_q - 1'b1;
				if (left_q == {{(SIZE_BITS-1){1'b0}}, 1'b1}) begin
					trail_d = 1'b0;
					phase_d = PH_TRAIL;
				end
			end
			PH_TRAIL: begin
				if (trail_q || byte_in == CH_LF) begin
					trail_d = 1'b0;
					phase_d = PH_SIZE;
				end else begin
					trail_d = 1'b1;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase
		if (!step) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SIZE;
			accum_q      <= '0;
			digit_seen_q <= 1'b0;
			stopped_q    <= 1'b0;
			left_q       <= '0;
			trail_q      <= 1'b0;
			cr_q         <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			accum_q      <= accum_d;
			digit_seen_q <= digit_seen_d;
			stopped_q    <= stopped_d;
			left_q       <= left_d;
			trail_q      <= trail_d;
			cr_q         <= cr_d;
		end
	end

	a_data_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> left_q != '0)
		else $error("data phase with an empty byte count");

	a_done_terminal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("left the done phase");

	a_line_end_clears_cr: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.line_end |=> !cr_q)
		else $error("CR still held after a line end");

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.has_byte && res.line_end) && phase_q == PH_DATA)
		else $error("malformed result");

endmodule

`default_nettype wire

[design/cbls_out_stage.sv]
// Result register stage of the chunked body line splitter.
// Holds one result until the consumer takes it. Depends on cbls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbls_out_stage
	import cbls_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t res,
	output logic         free,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      res_s2
);

	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

endmodule

`default_nettype wire

[design/chunked_body_line_splitter.sv]
// Top level of the chunked body line splitter.
// Depends on cbls_pkg, cbls_in_stage, cbls_decoder and cbls_out_stage.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    in_byte[7:0]
//   output    out_valid / out_ready  lead_cr, has_byte, out_byte[7:0], line_end
//
// A byte is registered on its transfer and decoded once the result register is
// free, and its result is registered in the output stage; one byte per cycle is
// sustained while the output side keeps taking results.
// A byte is decoded only when the result register is free or being drained.
// Reset clears the decoder to the size line phase and empties both stages.
// Bytes in the size, trailer and done phases, and a CR that is held, produce
// no result transfer.
`timescale 1ns / 1ps
`default_nettype none

module chunked_body_line_splitter
	import cbls_pkg::*;
#(
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            lead_cr,
	output logic            has_byte,
	output logic [7:0]      out_byte,
	output logic            line_end
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       take;
	logic       free;
	logic       res_valid;
	result_t    res;
	result_t    res_s2;

	// The held byte moves on whenever the result register can accept a result.
	assign take = valid_s1 && free;

	cbls_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	cbls_decoder #(
		.SIZE_BITS (SIZE_BITS)
	) u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (take),
		.byte_in   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	cbls_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_s2    (res_s2)
	);

	assign lead_cr  = res_s2.lead_cr;
	assign has_byte = res_s2.has_byte;
	assign out_byte = res_s2.out_byte;
	assign line_end = res_s2.line_end;

endmodule

`default_nettype wire
